>>> sv/btt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btt_pkg
// Shared types and constants for the 64x64 bit tile transpose block.
// ----------------------------------------------------------------------------
package btt_pkg;

    localparam int unsigned WORD_W        = 64;  // width of src/dst words
    localparam int unsigned TILE_BITS_DEF = 64;  // default tile size

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic load;   // shift a source word into the tile buffer
        logic emit;   // gather one column and shift the buffer down
        logic last;   // column being emitted is the last of the tile
    } t_cmd;

endpackage
`default_nettype wire

>>> sv/btt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btt_ctrl
// Load/emit sequencer: counts source words in, then counts columns out.
// ----------------------------------------------------------------------------
module btt_ctrl #(
    parameter int unsigned TILE_BITS = btt_pkg::TILE_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output      logic          o_busy,
    output      btt_pkg::t_cmd o_cmd
);

    localparam int unsigned CNT_W = $clog2(TILE_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TILE_BITS - 1);

    btt_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_at_last;

    assign w_at_last = (r_count == CNT_LAST);

    // next state and counter
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            btt_pkg::ST_LOAD: begin
                if (i_start) begin
                    if (w_at_last) begin
                        n_count = '0;
                        n_state = btt_pkg::ST_EMIT;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            btt_pkg::ST_EMIT: begin
                if (w_at_last) begin
                    n_count = '0;
                    n_state = btt_pkg::ST_LOAD;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
                n_count = '0;
                n_state = btt_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_busy     = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        o_cmd.last = 1'b0;
        case (r_state)
            btt_pkg::ST_LOAD: begin
                o_cmd.load = i_start;
            end
            btt_pkg::ST_EMIT: begin
                o_busy     = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.last = w_at_last;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btt_pkg::ST_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> sv/btt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btt_dp
// Tile buffer as a shift line of words; columns come out of bit 0 of each row.
// ----------------------------------------------------------------------------
module btt_dp #(
    parameter int unsigned TILE_BITS = btt_pkg::TILE_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire btt_pkg::t_cmd              i_cmd,
    input  wire logic [btt_pkg::WORD_W-1:0] i_src_word,
    output      logic                       o_dst_valid,
    output      logic [btt_pkg::WORD_W-1:0] o_dst_word,
    output      logic                       o_last_of_tile
);

    // after a full load, r_buf[b] holds source word b
    logic [TILE_BITS-1:0]       r_buf [TILE_BITS];
    logic [TILE_BITS-1:0]       w_col;
    logic [btt_pkg::WORD_W-1:0] r_dst_word;
    logic                       r_dst_valid;
    logic                       r_last;

    always_comb begin
        for (int b = 0; b < TILE_BITS; b++) begin
            w_col[b] = r_buf[b][0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < TILE_BITS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
            r_buf[TILE_BITS-1] <= i_src_word[TILE_BITS-1:0];
        end else if (i_cmd.emit) begin
            // each row steps right so the next column sits at bit 0
            for (int i = 0; i < TILE_BITS; i++) begin
                r_buf[i] <= r_buf[i] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_dst_word <= btt_pkg::WORD_W'(w_col);
            r_last     <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_valid <= 1'b0;
        end else begin
            r_dst_valid <= i_cmd.emit;
        end
    end

    assign o_dst_valid    = r_dst_valid;
    assign o_dst_word     = r_dst_word;
    assign o_last_of_tile = r_last;

endmodule
`default_nettype wire

>>> sv/bit_tile_transpose_64.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bit_tile_transpose_64
// Transposes one TILE_BITS x TILE_BITS bit tile: loads source words, then
// emits the transposed words with the final one flagged.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | start & !busy        | i_src_word[63:0]
//  out      | o_dst_valid          | o_dst_word[63:0], o_last_of_tile
//
//  A source word is loaded when start is high; after the TILE_BITS-th word
//  the block holds busy while the emit counter walks the columns,
//  one output item per cycle. No source word is taken during the emit,
//  as the single tile buffer is shared by load and emit. Outputs are
//  registered and appear in the cycle after the emit cycle; the next tile's
//  first word may be taken in the cycle the last output is shown.
//  Reset clears the controller (load count zero) and the output strobe; the
//  tile buffer is not reset. The receiver cannot stall, so no backpressure.
//  Source bits at and above TILE_BITS are dropped; output bits there are 0.
// ----------------------------------------------------------------------------
module bit_tile_transpose_64 #(
    parameter int unsigned TILE_BITS = btt_pkg::TILE_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output      logic                       busy,
    input  wire logic [btt_pkg::WORD_W-1:0] i_src_word,
    output      logic                       o_dst_valid,
    output      logic [btt_pkg::WORD_W-1:0] o_dst_word,
    output      logic                       o_last_of_tile
);

    btt_pkg::t_cmd w_cmd;

    // sequencer: load count, emit count, busy
    btt_ctrl #(
        .TILE_BITS(TILE_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    // tile buffer and output registers
    btt_dp #(
        .TILE_BITS(TILE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_src_word     (i_src_word),
        .o_dst_valid    (o_dst_valid),
        .o_dst_word     (o_dst_word),
        .o_last_of_tile (o_last_of_tile)
    );

endmodule
`default_nettype wire
